/* rtl/awbm_pkg.sv */
// Package: transaction types, opcodes and the radix-2 Booth step for the ALU.
package awbm_pkg;

    localparam logic [3:0] OPC_ADD = 4'h1;
    localparam logic [3:0] OPC_SUB = 4'h2;
    localparam logic [3:0] OPC_MUL = 4'h3;
    localparam logic [3:0] OPC_AND = 4'h4;
    localparam logic [3:0] OPC_OR  = 4'h5;
    localparam logic [3:0] OPC_NOT = 4'h6;
    localparam logic [3:0] OPC_XOR = 4'h7;
    localparam logic [3:0] OPC_SHR = 4'h8;
    localparam logic [3:0] OPC_SHL = 4'h9;

    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [15:0] acc;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
        logic        carry_flag;
    } rsp_t;

    typedef struct packed {
        logic [7:0] ra;
        logic [7:0] rq;
        logic       qm1;
    } booth_t;

    typedef struct packed {
        logic        mul;
        logic [15:0] acc;
        logic [7:0]  m;
        booth_t      st;
    } stage_t;

    // One Booth step: add/subtract into the 8-bit A register, then arithmetic shift A:Q.
    function automatic booth_t booth_step(booth_t s, logic [7:0] m);
        logic [7:0] sum;
        booth_t     r;
        unique case ({s.rq[0], s.qm1})
            BOOTH_SUB: sum = s.ra - m;
            BOOTH_ADD: sum = s.ra + m;
            default:   sum = s.ra;
        endcase
        r.ra  = {sum[7], sum[7:1]};
        r.rq  = {sum[0], s.rq[7:1]};
        r.qm1 = s.rq[0];
        return r;
    endfunction

endpackage

/* rtl/alu_with_booth_multiply_unit.sv */
// Top level: pipelined 8-bit ALU with radix-2 Booth multiply and four flags.
//
// Accepts one transaction per clock while req_stall is low, and returns one result per
// transaction, in order. A transaction passes through an input decode register, four
// Booth stages of two steps each, and the flag/output register. Every opcode runs
// through the same six stages. A stall on the result side holds each full stage in
// place; empty stages still fill, and req_stall rises only once the whole pipe is
// full.
module alu_with_booth_multiply_unit
    import awbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req,
    output logic req_stall,
    output logic rsp_valid,
    output rsp_t rsp,
    input  logic rsp_stall
);

    logic   dec_valid_reg;
    stage_t dec_reg;
    stage_t dec_next;
    logic   dec_stall;

    logic   pv [0:4];
    stage_t pd [0:4];
    logic   ps [0:4];

    logic   rsp_valid_reg;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    logic   out_stall;
    logic [15:0] res;
    logic [7:0]  nb;

    // decode
    always_comb
    begin
        nb           = ~req.operand_b + 8'd1;
        dec_next.mul = (req.kind == OPC_MUL);
        dec_next.m   = req.operand_a;
        dec_next.st  = '{ra: 8'd0, rq: req.operand_b, qm1: 1'b0};
        unique case (req.kind)
            OPC_ADD: dec_next.acc = 16'({1'b0, req.operand_a} + {1'b0, req.operand_b});
            OPC_SUB: dec_next.acc = 16'({1'b0, req.operand_a} + {1'b0, nb});
            OPC_AND: dec_next.acc = {8'd0, req.operand_a & req.operand_b};
            OPC_OR:  dec_next.acc = {8'd0, req.operand_a | req.operand_b};
            OPC_NOT: dec_next.acc = {8'd0, ~req.operand_a};
            OPC_XOR: dec_next.acc = {8'd0, req.operand_a ^ req.operand_b};
            OPC_SHR: dec_next.acc = {9'd0, req.operand_a[7:1]};
            OPC_SHL: dec_next.acc = {7'd0, req.operand_a, 1'b0};
            default: dec_next.acc = 16'd0;
        endcase
    end

    assign dec_stall = dec_valid_reg && ps[0];
    assign req_stall = dec_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (!dec_stall)
        begin
            dec_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!dec_stall)
        begin
            dec_reg <= dec_next;
        end
    end

    assign pv[0] = dec_valid_reg;
    assign pd[0] = dec_reg;
    assign ps[4] = out_stall;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_booth
            awbm_booth_stage u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (pv[g]),
                .up       (pd[g]),
                .up_stall (ps[g]),
                .dn_valid (pv[g+1]),
                .dn       (pd[g+1]),
                .dn_stall (ps[g+1])
            );
        end
    endgenerate

    // result select and flags
    always_comb
    begin
        res                    = pd[4].mul ? {pd[4].st.ra, pd[4].st.rq} : pd[4].acc;
        rsp_next.acc           = res;
        rsp_next.zero_flag     = (res == 16'd0);
        rsp_next.sign_flag     = res[7];
        rsp_next.overflow_flag = |res[15:7];
        rsp_next.carry_flag    = |res[15:8];
    end

    assign out_stall = rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!out_stall)
        begin
            rsp_valid_reg <= pv[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_stall)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_carry_implies_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.carry_flag |-> rsp.overflow_flag)
        else $error("carry without overflow");

    a_zero_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.zero_flag |-> !rsp.sign_flag && !rsp.overflow_flag)
        else $error("zero flag with nonzero bits");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> pv[0] && pv[1] && pv[2] && pv[3] && pv[4] && rsp_valid)
        else $error("input stalled with a bubble in the pipe");

    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(pv[4]))
        else $error("result without a transaction in the last stage");

endmodule

/* rtl/awbm_booth_stage.sv */
// Pipeline stage: two Booth steps on the multiply state, other results pass through.
module awbm_booth_stage
    import awbm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  stage_t up,
    output logic   up_stall,
    output logic   dn_valid,
    output stage_t dn,
    input  logic   dn_stall
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        data_next    = up;
        data_next.st = booth_step(booth_step(up.st, up.m), up.m);
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn       = data_reg;

endmodule
